/* sv/gclt_pkg.sv */
// shared types and constants for the gate crossing lap timer
// no dependencies; imported by every module of the block
`default_nettype none

package gclt_pkg;

  localparam int unsigned POS_W    = 24;
  localparam int unsigned VEL_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LAP_W    = 16;
  localparam int unsigned SPD_W    = 16;
  localparam int unsigned DIFF_W   = POS_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned REG_IW   = 3;

  // register indexes (byte address / 4)
  localparam logic [REG_IW-1:0] REG_MODE   = 3'd0;
  localparam logic [REG_IW-1:0] REG_GATE_AX = 3'd1;
  localparam logic [REG_IW-1:0] REG_GATE_AY = 3'd2;
  localparam logic [REG_IW-1:0] REG_GATE_BX = 3'd3;
  localparam logic [REG_IW-1:0] REG_GATE_BY = 3'd4;

  localparam logic MODE_LAP   = 1'b0;
  localparam logic MODE_ACCEL = 1'b1;

  localparam logic signed [POS_W-1:0] GATE_AY_RST = POS_W'(512);
  localparam logic signed [POS_W-1:0] GATE_BY_RST = POS_W'(-512);

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic        [TIME_W-1:0] time_now;
  } gclt_in_t;

  typedef struct packed {
    logic              crossed;
    logic [LAP_W-1:0]  lap_count;
    logic [TIME_W-1:0] lap_time;
    logic              lap_time_valid;
    logic [SPD_W-1:0]  speed_avg;
  } gclt_out_t;

  typedef struct packed {
    logic                    mode;
    logic signed [POS_W-1:0] gate_a_x;
    logic signed [POS_W-1:0] gate_a_y;
    logic signed [POS_W-1:0] gate_b_x;
    logic signed [POS_W-1:0] gate_b_y;
  } gclt_cfg_t;

endpackage

`default_nettype wire

/* sv/gclt_apb_regs.sv */
// apb configuration registers: mode and the two gate endpoints
// depends on gclt_pkg
`default_nettype none

module gclt_apb_regs (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [gclt_pkg::APB_AW-1:0]    paddr,
  input  wire  [gclt_pkg::APB_DW-1:0]    pwdata,
  output logic [gclt_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output gclt_pkg::gclt_cfg_t            cfg_o
);
  import gclt_pkg::*;

  gclt_cfg_t         cfg_q;
  logic              wr_en;
  logic [REG_IW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= MODE_LAP;
      cfg_q.gate_a_x <= '0;
      cfg_q.gate_a_y <= GATE_AY_RST;
      cfg_q.gate_b_x <= '0;
      cfg_q.gate_b_y <= GATE_BY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:    cfg_q.mode     <= pwdata[0];
        REG_GATE_AX: cfg_q.gate_a_x <= pwdata[POS_W-1:0];
        REG_GATE_AY: cfg_q.gate_a_y <= pwdata[POS_W-1:0];
        REG_GATE_BX: cfg_q.gate_b_x <= pwdata[POS_W-1:0];
        REG_GATE_BY: cfg_q.gate_b_y <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:    prdata = {{(APB_DW-1){1'b0}}, cfg_q.mode};
      REG_GATE_AX: prdata = {{(APB_DW-POS_W){1'b0}}, cfg_q.gate_a_x};
      REG_GATE_AY: prdata = {{(APB_DW-POS_W){1'b0}}, cfg_q.gate_a_y};
      REG_GATE_BX: prdata = {{(APB_DW-POS_W){1'b0}}, cfg_q.gate_b_x};
      REG_GATE_BY: prdata = {{(APB_DW-POS_W){1'b0}}, cfg_q.gate_b_y};
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/gclt_mul.sv */
// shared signed multiplier: registered operands, registered product
// depends on gclt_pkg; operands pass through a_q and b_q, then the product through prod_q
`default_nettype none

module gclt_mul (
  input  wire                                   clk_i,
  input  wire  signed [gclt_pkg::DIFF_W-1:0]    a_i,
  input  wire  signed [gclt_pkg::DIFF_W-1:0]    b_i,
  output logic signed [gclt_pkg::PROD_W-1:0]    prod_o
);
  import gclt_pkg::*;

  logic signed [DIFF_W-1:0] a_q, b_q;
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    b_q    <= b_i;
    prod_q <= a_q * b_q;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* sv/gclt_isqrt.sv */
// iterative integer square root; a new start abandons any root still in progress
// depends on gclt_pkg
`default_nettype none

module gclt_isqrt (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [gclt_pkg::SQ_W-1:0]      value_i,
  output logic                           done_o,
  output logic [gclt_pkg::SPD_W-1:0]     root_o
);
  import gclt_pkg::*;

  logic            busy_q, done_q;
  logic [SQ_W-1:0] rem_q, res_q, bit_q;
  logic [SQ_W:0]   trial;
  logic            fits;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign fits  = {1'b0, rem_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial[SQ_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[SPD_W-1:0];

endmodule

`default_nettype wire

/* sv/gate_crossing_lap_timer_unit.sv */
// gate crossing lap timer, top level
// sequence: 12 multiplier steps for four orientation tests and vx^2+vy^2,
// then 16 square root steps (shared multiplier, iterative square root unit)
// a new request is taken only after the result of the last one is registered
// for output; in_stall_o is high while a request is worked on
// reset: asynchronous, clears sequencer, lap state, speed average; sets gate regs to defaults
`default_nettype none

module gate_crossing_lap_timer_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  gclt_pkg::gclt_in_t             in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output gclt_pkg::gclt_out_t            out_data_o,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [gclt_pkg::APB_AW-1:0]    paddr,
  input  wire  [gclt_pkg::APB_DW-1:0]    pwdata,
  output logic [gclt_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import gclt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  localparam logic [3:0] STEP_LAST = 4'd11;
  localparam logic [3:0] PIDX_SQ0  = 4'd8;

  gclt_cfg_t cfg;

  state_e            state_q, state_d;
  logic [3:0]        step_q;
  gclt_in_t          smp_q;
  logic signed [POS_W-1:0] prev_x_q, prev_y_q;
  logic [LAP_W-1:0]  laps_q;
  logic [TIME_W-1:0] lap_start_q;
  logic [SPD_W-1:0]  avg_q;
  logic [3:0]        orient_q;
  logic signed [PROD_W-1:0] first_q;
  logic [SQ_W-1:0]   sq_q;
  logic              out_valid_q;
  gclt_out_t         out_q;

  logic              in_acc, out_free, finish;
  logic signed [POS_W-1:0] px, py, qx, qy, rx, ry;
  logic signed [DIFF_W-1:0] op_a, op_b, vx_e, vy_e;
  logic signed [PROD_W-1:0] prod;
  logic [3:0]        pidx;
  logic              sqrt_start, sqrt_done;
  logic [SQ_W-1:0]   sq_sum;
  logic [SPD_W-1:0]  root;

  logic              hit, lap_en, ltv;
  logic [LAP_W-1:0]  laps_nx;
  logic [SPD_W:0]    avg_sum;
  logic [SPD_W-1:0]  avg_nx;

  gclt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == ST_DONE) && out_free;

  // point selection: A, B gate ends; C previous position; D new position
  always_comb begin
    unique case (step_q[2:1])
      2'd0: begin
        px = cfg.gate_a_x; py = cfg.gate_a_y;
        qx = prev_x_q;     qy = prev_y_q;
        rx = smp_q.pos_x;  ry = smp_q.pos_y;
      end
      2'd1: begin
        px = cfg.gate_b_x; py = cfg.gate_b_y;
        qx = prev_x_q;     qy = prev_y_q;
        rx = smp_q.pos_x;  ry = smp_q.pos_y;
      end
      2'd2: begin
        px = cfg.gate_a_x; py = cfg.gate_a_y;
        qx = cfg.gate_b_x; qy = cfg.gate_b_y;
        rx = prev_x_q;     ry = prev_y_q;
      end
      default: begin
        px = cfg.gate_a_x; py = cfg.gate_a_y;
        qx = cfg.gate_b_x; qy = cfg.gate_b_y;
        rx = smp_q.pos_x;  ry = smp_q.pos_y;
      end
    endcase
  end

  assign vx_e = {{(DIFF_W-VEL_W){smp_q.vel_x[VEL_W-1]}}, smp_q.vel_x};
  assign vy_e = {{(DIFF_W-VEL_W){smp_q.vel_y[VEL_W-1]}}, smp_q.vel_y};

  // even step: (qx-px)*(ry-py), odd step: (qy-py)*(rx-px); from step 8 on: vx*vx even, vy*vy odd
  always_comb begin
    if (step_q[3]) begin
      op_a = step_q[0] ? vy_e : vx_e;
      op_b = op_a;
    end else if (step_q[0]) begin
      op_a = {qy[POS_W-1], qy} - {py[POS_W-1], py};
      op_b = {rx[POS_W-1], rx} - {px[POS_W-1], px};
    end else begin
      op_a = {qx[POS_W-1], qx} - {px[POS_W-1], px};
      op_b = {ry[POS_W-1], ry} - {py[POS_W-1], py};
    end
  end

  gclt_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // product of step s passes the multiplier's operand and product registers; pidx names its step
  assign pidx       = step_q - 4'd2;
  assign sq_sum     = sq_q + prod[SQ_W-1:0];
  assign sqrt_start = (state_q == ST_MUL) && (step_q == STEP_LAST);

  gclt_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sq_sum),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MUL;
      ST_MUL:  if (step_q == STEP_LAST) state_d = ST_SQRT;
      ST_SQRT: if (sqrt_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // result of this request
  assign hit     = (orient_q[0] ^ orient_q[1]) && (orient_q[2] ^ orient_q[3]);
  assign lap_en  = hit && (cfg.mode == MODE_LAP);
  assign laps_nx = (lap_en && (laps_q != {LAP_W{1'b1}})) ? laps_q + LAP_W'(1) : laps_q;
  assign ltv     = lap_en && (laps_nx != LAP_W'(1));
  assign avg_sum = {1'b0, root} + {1'b0, avg_q};
  assign avg_nx  = (avg_q == '0) ? root : avg_sum[SPD_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      laps_q      <= '0;
      lap_start_q <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        step_q <= '0;
      end else if (state_q == ST_MUL) begin
        step_q <= step_q + 4'd1;
      end
      if (finish) begin
        prev_x_q <= smp_q.pos_x;
        prev_y_q <= smp_q.pos_y;
        laps_q   <= laps_nx;
        avg_q    <= avg_nx;
        if (hit) lap_start_q <= smp_q.time_now;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // the second velocity product feeds the root directly
  always_ff @(posedge clk_i) begin
    if (in_acc) smp_q <= in_data_i;
    if ((state_q == ST_MUL) && (step_q >= 4'd2)) begin
      if (!pidx[3]) begin
        if (!pidx[0]) first_q <= prod;
        else          orient_q[pidx[2:1]] <= first_q > prod;
      end else if (pidx == PIDX_SQ0) begin
        sq_q <= prod[SQ_W-1:0];
      end
    end
    if (finish) begin
      out_q.crossed        <= hit;
      out_q.lap_count      <= laps_nx;
      out_q.lap_time       <= ltv ? smp_q.time_now - lap_start_q : '0;
      out_q.lap_time_valid <= ltv;
      out_q.speed_avg      <= avg_nx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* tb/gate_crossing_lap_timer_unit_test.sv */
// self-checking testbench for gate_crossing_lap_timer_unit
// depends on gclt_pkg and the block's rtl; predicts every sample result in-line
// directed table first, then random gate phases, then a run of laps across the reset gate

module gate_crossing_lap_timer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gclt_pkg::*;

  localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));
  localparam longint VEL_MAX = 32767;
  localparam longint VEL_MIN = -32768;
  localparam logic [REG_IW-1:0] REG_SPARE = 3'd7;
  localparam logic [LAP_W-1:0] LAP_FULL = '1;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int SHUTTLE_ITEMS = 40;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int SQUEEZE_AT = 934;
  localparam longint RUN_LIMIT_NS = 200_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  gclt_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  gclt_out_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  gate_crossing_lap_timer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the block's registers and sample state
  gclt_cfg_t cfg_shadow;
  logic signed [POS_W-1:0] last_x, last_y;
  logic [LAP_W-1:0] lap_total;
  logic [TIME_W-1:0] lap_mark;
  logic [SPD_W-1:0] speed_mean;

  gclt_out_t pending[$];
  gclt_out_t head;
  int fault_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit squeeze_go = 1'b0;
  bit toward_left = 1'b0;
  logic [TIME_W-1:0] clock_ticks = '0;

  typedef struct {
    gclt_in_t  req;
    bit        typed;
    gclt_out_t want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic bit turns_left(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
    return (qx - px) * (ry - py) > (qy - py) * (rx - px);
  endfunction

  function automatic logic [SPD_W-1:0] int_sqrt(logic [SQ_W-1:0] v);
    logic [SPD_W-1:0] root;
    logic [SPD_W-1:0] trial;
    root = '0;
    for (int b = SPD_W - 1; b >= 0; b--) begin
      trial = root | (SPD_W'(1) << b);
      if (longint'(trial) * longint'(trial) <= longint'(v)) root = trial;
    end
    return root;
  endfunction

  function automatic gclt_out_t predict_sample(gclt_in_t s);
    longint ax, ay, bx, by, cx, cy, dx, dy, vx, vy;
    logic [SQ_W-1:0] sq;
    logic [SPD_W-1:0] spd;
    logic [SPD_W:0] sum;
    gclt_out_t r;
    bit hit;
    ax = $signed(cfg_shadow.gate_a_x);
    ay = $signed(cfg_shadow.gate_a_y);
    bx = $signed(cfg_shadow.gate_b_x);
    by = $signed(cfg_shadow.gate_b_y);
    cx = last_x;
    cy = last_y;
    dx = $signed(s.pos_x);
    dy = $signed(s.pos_y);
    vx = $signed(s.vel_x);
    vy = $signed(s.vel_y);
    r = '0;
    hit = (turns_left(ax, ay, cx, cy, dx, dy) != turns_left(bx, by, cx, cy, dx, dy)) &&
          (turns_left(ax, ay, bx, by, cx, cy) != turns_left(ax, ay, bx, by, dx, dy));
    if (hit) begin
      if (cfg_shadow.mode == MODE_LAP) begin
        if (lap_total != LAP_FULL) lap_total = lap_total + 1'b1;
        // the first lap only starts the clock
        if (lap_total != LAP_W'(1)) begin
          r.lap_time = s.time_now - lap_mark;
          r.lap_time_valid = 1'b1;
        end
      end
      lap_mark = s.time_now;
    end
    sq = SQ_W'(vx * vx + vy * vy);
    spd = int_sqrt(sq);
    if (speed_mean == '0) begin
      speed_mean = spd;
    end else begin
      sum = spd + speed_mean;
      speed_mean = sum[SPD_W:1];
    end
    last_x = s.pos_x;
    last_y = s.pos_y;
    r.crossed = hit;
    r.lap_count = lap_total;
    r.speed_avg = speed_mean;
    return r;
  endfunction

  function automatic longint jitter();
    return longint'($urandom_range(511)) - 256;
  endfunction

  function automatic longint rnd_coord(int sh);
    logic signed [POS_W-1:0] r;
    r = POS_W'($urandom);
    return longint'(r) >>> sh;
  endfunction

  function automatic logic signed [POS_W-1:0] fit_pos(longint v);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return POS_W'(v);
  endfunction

  // mostly motion back and forth across the gate near its middle, some points on
  // the gate or its extension, some noise over the whole plane
  function automatic gclt_in_t random_sample();
    gclt_in_t s;
    longint ax, ay, bx, by, mx, my, px, py, dv;
    int pick;
    ax = $signed(cfg_shadow.gate_a_x);
    ay = $signed(cfg_shadow.gate_a_y);
    bx = $signed(cfg_shadow.gate_b_x);
    by = $signed(cfg_shadow.gate_b_y);
    mx = (ax + bx) / 2;
    my = (ay + by) / 2;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(99) < 85) toward_left = !toward_left;
      dv = longint'(1) << $urandom_range(6);
      px = mx + (toward_left ? (ay - by) : (by - ay)) / dv + jitter();
      py = my + (toward_left ? (bx - ax) : (ax - bx)) / dv + jitter();
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0: begin
          px = ax;
          py = ay;
        end
        1: begin
          px = bx;
          py = by;
        end
        2: begin
          px = mx;
          py = my;
        end
        default: begin
          px = 2 * bx - ax;
          py = 2 * by - ay;
        end
      endcase
    end else begin
      px = rnd_coord(0);
      py = rnd_coord(0);
    end
    s.pos_x = fit_pos(px);
    s.pos_y = fit_pos(py);
    if ($urandom_range(3) == 0) begin
      s.vel_x = VEL_W'(jitter());
      s.vel_y = VEL_W'(jitter());
    end else begin
      s.vel_x = VEL_W'($urandom);
      s.vel_y = VEL_W'($urandom);
    end
    if ($urandom_range(19) == 0) clock_ticks = $urandom;
    else clock_ticks = clock_ticks + $urandom_range(1, 100000);
    s.time_now = clock_ticks;
    return s;
  endfunction

  task automatic add_row(longint px, longint py, longint vx, longint vy, longint t,
                         bit typed = 1'b0, bit c = 1'b0, int lc = 0, longint lt = 0,
                         bit ltv = 1'b0, int spd = 0);
    plan_row_t row;
    row.req.pos_x = POS_W'(px);
    row.req.pos_y = POS_W'(py);
    row.req.vel_x = VEL_W'(vx);
    row.req.vel_y = VEL_W'(vy);
    row.req.time_now = TIME_W'(t);
    row.typed = typed;
    row.want.crossed = c;
    row.want.lap_count = LAP_W'(lc);
    row.want.lap_time = TIME_W'(lt);
    row.want.lap_time_valid = ltv;
    row.want.speed_avg = SPD_W'(spd);
    plan.push_back(row);
  endtask

  // offer one request until it is taken, then queue what it should produce
  task automatic offer_sample(gclt_in_t s, bit typed, gclt_out_t typed_want);
    gclt_out_t model_out;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    model_out = predict_sample(s);
    pending.push_back(typed ? typed_want : model_out);
  endtask

  // psel stays high between back-to-back writes, the caller drops it
  task automatic reg_write(logic [REG_IW-1:0] idx, longint value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MODE:    cfg_shadow.mode = value[0];
      REG_GATE_AX: cfg_shadow.gate_a_x = POS_W'(value);
      REG_GATE_AY: cfg_shadow.gate_a_y = POS_W'(value);
      REG_GATE_BX: cfg_shadow.gate_b_x = POS_W'(value);
      REG_GATE_BY: cfg_shadow.gate_b_y = POS_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_gate(logic mode, longint ax, longint ay, longint bx, longint by,
                            bit poke_spare = 1'b0);
    reg_write(REG_MODE, mode);
    reg_write(REG_GATE_AX, ax);
    reg_write(REG_GATE_AY, ay);
    reg_write(REG_GATE_BX, bx);
    reg_write(REG_GATE_BY, by);
    if (poke_spare) reg_write(REG_SPARE, longint'($urandom));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(string tag, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10) $display("mismatch on %s: expected %0h, got %0h", tag, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("result with no request pending: %h", out_data_o);
      end else begin
        head = pending.pop_front();
        compare_field("crossed", head.crossed, out_data_o.crossed);
        compare_field("lap_count", head.lap_count, out_data_o.lap_count);
        compare_field("lap_time", head.lap_time, out_data_o.lap_time);
        compare_field("lap_time_valid", head.lap_time_valid, out_data_o.lap_time_valid);
        compare_field("speed_avg", head.speed_avg, out_data_o.speed_avg);
      end
    end
  end

  // result side: random stall, plus one long hold-off to back the block up
  initial begin : result_sink
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_go) begin
        squeeze_go = 1'b0;
        out_stall_i <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    gclt_in_t s;
    int idx;
    int extra;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_ni <= 1'b0;
    cfg_shadow.mode = MODE_LAP;
    cfg_shadow.gate_a_x = '0;
    cfg_shadow.gate_a_y = GATE_AY_RST;
    cfg_shadow.gate_b_x = '0;
    cfg_shadow.gate_b_y = GATE_BY_RST;
    last_x = '0;
    last_y = '0;
    lap_total = '0;
    lap_mark = '0;
    speed_mean = '0;

    // reset gate is the vertical segment x = 0, y in [-512, 512]
    add_row(0, 0, 0, 0, 100, 1, 0, 0, 0, 0, 0);
    add_row(-256, 0, 3, 4, 200, 1, 0, 0, 0, 0, 5);      // starts on the gate: touch only
    add_row(256, 0, 0, 0, 300, 1, 1, 1, 0, 0, 2);       // first lap starts the clock
    add_row(-256, 0, 0, 0, 1300, 1, 1, 2, 1000, 1, 1);
    add_row(0, 256, -1, -1, 1400);                      // ends on the gate
    add_row(0, -256, VEL_MIN, VEL_MIN, 1500);           // runs along the gate
    add_row(0, -512, VEL_MAX, VEL_MAX, 1600);
    add_row(POS_MAX, POS_MAX, VEL_MIN, 0, 64'hFFFF_FFFF);
    add_row(POS_MIN, POS_MIN, VEL_MAX, VEL_MIN, 0);     // crossing with a wrapped lap time
    add_row(POS_MAX, POS_MIN, 0, VEL_MIN, 64'h7FFF_FFFF);
    add_row(POS_MIN, POS_MAX, -1, -1, 64'h8000_0000);
    add_row(512, 0, 255, -256, 64'h8000_0100);
    add_row(0, 0, -256, 255, 64'h8000_0200);
    add_row(-512, -512, 0, 0, 64'h8000_0300);
    add_row(512, 512, 100, -100, 64'h8000_0400);        // through the middle of the gate
    add_row(512, 600, 0, 0, 64'h8000_0500);
    add_row(-512, 600, 0, 0, 64'h8000_0600);
    add_row(512, 512, 0, 0, 64'h8000_0700);             // passes just above an end
    clock_ticks = 32'h8000_0700;

    tx_idle_pct = 18;
    rx_idle_pct = 50;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) offer_sample(plan[i].req, plan[i].typed, plan[i].want);

    idx = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: apply_gate(MODE_LAP, 0, 512, 0, -512);
        1: apply_gate(MODE_ACCEL, rnd_coord(12), rnd_coord(12), rnd_coord(12), rnd_coord(12),
                      1'b1);
        2: apply_gate(MODE_LAP, POS_MIN, POS_MIN, POS_MAX, POS_MAX);
        3: begin
          // zero-length gate
          extra = $urandom_range(8191);
          apply_gate(MODE_LAP, extra, -extra, extra, -extra);
        end
        4: apply_gate(MODE_ACCEL, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
        5: apply_gate(MODE_LAP, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
        default: begin
          extra = $urandom_range(14);
          apply_gate(1'($urandom_range(1)), rnd_coord(extra), rnd_coord(extra),
                     rnd_coord(extra), rnd_coord(extra));
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        if (idx < 467) begin
          tx_idle_pct = 18;
          rx_idle_pct = 50;
        end else if (idx < SQUEEZE_AT) begin
          tx_idle_pct = 50;
          rx_idle_pct = 18;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        if (idx == SQUEEZE_AT) squeeze_go = 1'b1;
        offer_sample(random_sample(), 1'b0, '0);
        idx++;
      end
    end

    // shuttle across the reset gate, one lap per request
    settle();
    apply_gate(MODE_LAP, 0, 512, 0, -512);
    repeat (SHUTTLE_ITEMS) begin
      toward_left = !toward_left;
      s.pos_x = toward_left ? POS_W'(-256) : POS_W'(256);
      s.pos_y = POS_W'(jitter());
      s.vel_x = VEL_W'($urandom);
      s.vel_y = VEL_W'($urandom);
      clock_ticks = clock_ticks + $urandom_range(1, 5000);
      s.time_now = clock_ticks;
      offer_sample(s, 1'b0, '0);
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (fault_count == 0 && pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/gclt_pkg.sv
sv/gclt_apb_regs.sv
sv/gclt_mul.sv
sv/gclt_isqrt.sv
sv/gate_crossing_lap_timer_unit.sv
tb/gate_crossing_lap_timer_unit_test.sv
